@@ rtl/core/assert_macros.svh @@
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define SPS_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define SPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// next-cycle implication that also holds across reset
`define SPS_ASSERT_NEXT_NR(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/sps_pkg.sv @@
// ----------------------------------------------------------------------------
// sps_pkg
// Types, constants and helpers of the byte stream cipher core.
// ----------------------------------------------------------------------------
package sps_pkg;

  localparam int KEY_BYTES = 8;
  localparam int KEY_W     = 64;
  localparam int CUR_W     = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
  localparam int ACC_W     = 10;
  localparam int TRIES     = 12;
  localparam int TRY_W     = 4;
  localparam int STEP_W    = 5;

  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_REKEY   = 1'b1;

  localparam logic ST_ENCRYPTED = 1'b0;
  localparam logic ST_REKEYED   = 1'b1;

  typedef struct packed {
    logic       opcode;
    logic [7:0] plain_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] cipher_byte;
    logic       status;
  } out_item_t;

  typedef struct packed {
    logic       we;
    logic [7:0] addr;
    logic [7:0] wdata;
  } mem_req_t;

  // smallest 2^n-1 not below the slot
  function automatic logic [7:0] slot_mask(input logic [7:0] s);
    logic [7:0] m;
    m = s;
    m = m | (m >> 1);
    m = m | (m >> 2);
    m = m | (m >> 4);
    return m;
  endfunction

endpackage

@@ rtl/core/sapphire_stream_cipher_core.sv @@
// ----------------------------------------------------------------------------
// sapphire_stream_cipher_core
// Byte stream cipher with a 256-entry permutation held in one memory.
//
//   channel   signals                     payload
//   input     in_valid / in_stall         in_data  (opcode, plain_byte)
//   output    out_valid / out_stall       out_data (cipher_byte, status)
//   config    cfg_we                      cfg_wdata (session key)
//
// encrypt: a new request is accepted only after the previous result has left the
// sequencer, set by the chain of dependent reads and writes through the single port
// rekey: identity fill, then a key-schedule swap for each of 255 slots, then pointer seeding
// after reset a clearing pass loads the identity into all 256 entries; in_stall is high
// throughout it; out_stall holds the finished result and keeps the sequencer waiting
// ----------------------------------------------------------------------------
module sapphire_stream_cipher_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  sps_pkg::in_item_t         in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output sps_pkg::out_item_t        out_data,
  input  logic                      cfg_we,
  input  logic [sps_pkg::KEY_W-1:0] cfg_wdata
);

  logic [sps_pkg::KEY_W-1:0] session_key;
  logic                      idle, done_valid, out_free, start;
  sps_pkg::out_item_t        result;
  sps_pkg::mem_req_t         mem_req;
  logic [7:0]                rdata;

  assign in_stall = !idle;
  assign start    = in_valid && idle;
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      session_key <= '0;
    end else if (cfg_we) begin
      session_key <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= done_valid;
      if (done_valid) begin
        out_data <= result;
      end
    end
  end

  sps_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .item       (in_data),
    .key        (session_key),
    .out_free   (out_free),
    .idle       (idle),
    .done_valid (done_valid),
    .result     (result),
    .mem_req    (mem_req),
    .rdata      (rdata)
  );

  sps_perm_ram u_ram (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

endmodule

@@ rtl/core/sps_perm_ram.sv @@
// ----------------------------------------------------------------------------
// sps_perm_ram
// 256 x 8 single-port permutation memory, registered read data.
// ----------------------------------------------------------------------------
module sps_perm_ram (
  input  logic             clk,
  input  sps_pkg::mem_req_t req,
  output logic [7:0]       rdata
);

  logic [7:0] mem [256];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    rdata <= mem[req.addr];
  end

endmodule

@@ rtl/core/sps_ctrl.sv @@
// ----------------------------------------------------------------------------
// sps_ctrl
// Sequencer: table clear, key schedule, pointer seeding and byte encryption,
// all as reads and writes through the permutation memory.
// ----------------------------------------------------------------------------
module sps_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  sps_pkg::in_item_t       item,
  input  logic [sps_pkg::KEY_W-1:0] key,
  input  logic                    out_free,
  output logic                    idle,
  output logic                    done_valid,
  output sps_pkg::out_item_t      result,
  output sps_pkg::mem_req_t       mem_req,
  input  logic [7:0]              rdata
);

  localparam logic [3:0] S_CLEAR   = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_FILL    = 4'd2;
  localparam logic [3:0] S_TRY_RD  = 4'd3;
  localparam logic [3:0] S_TRY_EV  = 4'd4;
  localparam logic [3:0] S_SW_RI   = 4'd5;
  localparam logic [3:0] S_SW_RJ   = 4'd6;
  localparam logic [3:0] S_SW_WI   = 4'd7;
  localparam logic [3:0] S_SW_WJ   = 4'd8;
  localparam logic [3:0] S_SEED    = 4'd9;
  localparam logic [3:0] S_ENC     = 4'd10;
  localparam logic [3:0] S_DONE    = 4'd11;

  logic [3:0]                state;
  logic [sps_pkg::STEP_W-1:0] step;
  logic [7:0]                fill_cnt;
  logic [7:0]                slot;
  logic [sps_pkg::TRY_W-1:0] tries;
  logic [sps_pkg::ACC_W-1:0] acc;
  logic [sps_pkg::CUR_W-1:0] cur;
  logic [7:0]                jidx, ti;
  logic [7:0]                rotor, ratchet, aval, pprev, cprev;
  logic [7:0]                zreg, xsum, ysum, txr, plain;
  sps_pkg::out_item_t        res;

  // key schedule try
  logic [7:0]                kbyte, mask, pick;
  logic [sps_pkg::ACC_W-1:0] acc_sum, acc_next;
  logic                      cur_wrap;

  always_comb begin
    kbyte    = key[cur*8 +: 8];
    mask     = sps_pkg::slot_mask(slot);
    cur_wrap = (cur == sps_pkg::CUR_W'(sps_pkg::KEY_BYTES - 1));
    acc_sum  = sps_pkg::ACC_W'(rdata) + sps_pkg::ACC_W'(kbyte);
    acc_next = cur_wrap ? acc_sum + sps_pkg::ACC_W'(sps_pkg::KEY_BYTES) : acc_sum;
    pick     = acc_next[7:0] & mask;
  end

  always_comb begin
    mem_req = '0;
    case (state)
      S_CLEAR, S_FILL: begin
        mem_req.we    = 1'b1;
        mem_req.addr  = fill_cnt;
        mem_req.wdata = fill_cnt;
      end
      S_TRY_RD: mem_req.addr = acc[7:0];
      S_SW_RI:  mem_req.addr = slot;
      S_SW_RJ:  mem_req.addr = jidx;
      S_SW_WI: begin
        mem_req.we    = 1'b1;
        mem_req.addr  = slot;
        mem_req.wdata = rdata;
      end
      S_SW_WJ: begin
        mem_req.we    = 1'b1;
        mem_req.addr  = jidx;
        mem_req.wdata = ti;
      end
      S_SEED: begin
        case (step)
          5'd0:    mem_req.addr = 8'd1;
          5'd1:    mem_req.addr = 8'd3;
          5'd2:    mem_req.addr = 8'd5;
          5'd3:    mem_req.addr = 8'd7;
          default: mem_req.addr = acc[7:0];
        endcase
      end
      S_ENC: begin
        case (step)
          5'd0:  mem_req.addr = rotor;
          5'd1:  mem_req.addr = cprev;
          5'd2:  mem_req.addr = ratchet;
          5'd3:  mem_req = '{we: 1'b1, addr: cprev, wdata: rdata};
          5'd4:  mem_req.addr = pprev;
          5'd5:  mem_req = '{we: 1'b1, addr: ratchet, wdata: rdata};
          5'd6:  mem_req.addr = rotor;
          5'd7:  mem_req = '{we: 1'b1, addr: pprev, wdata: rdata};
          5'd8:  mem_req = '{we: 1'b1, addr: rotor, wdata: zreg};
          5'd9:  mem_req.addr = zreg;
          5'd10: mem_req.addr = ratchet;
          5'd11: mem_req.addr = pprev;
          5'd12: mem_req.addr = cprev;
          5'd13: mem_req.addr = rotor;
          5'd14: mem_req.addr = xsum;
          5'd15: mem_req.addr = aval;
          5'd16: mem_req.addr = txr;
          5'd17: mem_req.addr = ysum;
          default: mem_req.addr = 8'd0;
        endcase
      end
      default: mem_req = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      step     <= '0;
      fill_cnt <= '0;
      rotor    <= '0;
      ratchet  <= '0;
      aval     <= '0;
      pprev    <= '0;
      cprev    <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          fill_cnt <= fill_cnt + 8'd1;
          if (fill_cnt == 8'hFF) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            step     <= '0;
            fill_cnt <= '0;
            plain    <= item.plain_byte;
            state    <= (item.opcode == sps_pkg::OP_REKEY) ? S_FILL : S_ENC;
          end
        end
        S_FILL: begin
          fill_cnt <= fill_cnt + 8'd1;
          if (fill_cnt == 8'hFF) begin
            slot  <= 8'hFF;
            tries <= '0;
            acc   <= '0;
            cur   <= '0;
            state <= S_TRY_RD;
          end
        end
        S_TRY_RD: state <= S_TRY_EV;
        S_TRY_EV: begin
          acc <= acc_next;
          cur <= cur_wrap ? '0 : cur + sps_pkg::CUR_W'(1);
          if (pick <= slot) begin
            jidx  <= pick;
            state <= S_SW_RI;
          end else if (tries == sps_pkg::TRY_W'(sps_pkg::TRIES - 1)) begin
            // pick lies in (slot, 2*slot), so the remainder is one subtract
            jidx  <= pick - slot;
            state <= S_SW_RI;
          end else begin
            tries <= tries + sps_pkg::TRY_W'(1);
            state <= S_TRY_RD;
          end
        end
        S_SW_RI: state <= S_SW_RJ;
        S_SW_RJ: begin
          ti    <= rdata;
          state <= S_SW_WI;
        end
        S_SW_WI: state <= S_SW_WJ;
        S_SW_WJ: begin
          tries <= '0;
          if (slot == 8'd1) begin
            step  <= '0;
            state <= S_SEED;
          end else begin
            slot  <= slot - 8'd1;
            state <= S_TRY_RD;
          end
        end
        S_SEED: begin
          step <= step + 5'd1;
          case (step)
            5'd1: rotor   <= rdata;
            5'd2: ratchet <= rdata;
            5'd3: aval    <= rdata;
            5'd4: pprev   <= rdata;
            5'd5: begin
              cprev <= rdata;
              res   <= '{cipher_byte: 8'd0, status: sps_pkg::ST_REKEYED};
              state <= S_DONE;
            end
            default: ;
          endcase
        end
        S_ENC: begin
          step <= step + 5'd1;
          case (step)
            5'd1: begin
              ratchet <= ratchet + rdata;
              rotor   <= rotor + 8'd1;
            end
            5'd2:  zreg <= rdata;
            5'd10: aval <= aval + rdata;
            5'd11: xsum <= rdata;
            5'd12: xsum <= xsum + rdata;
            5'd13: xsum <= xsum + rdata;
            5'd14: ysum <= rdata;
            5'd15: txr  <= rdata;
            5'd16: ysum <= ysum + rdata;
            5'd17: txr  <= rdata;
            5'd18: begin
              cprev <= txr ^ rdata ^ plain;
              pprev <= plain;
              res   <= '{cipher_byte: txr ^ rdata ^ plain, status: sps_pkg::ST_ENCRYPTED};
              state <= S_DONE;
            end
            default: ;
          endcase
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  assign idle       = (state == S_IDLE);
  assign done_valid = (state == S_DONE);
  assign result     = res;

endmodule

@@ rtl/core/sps_checker.sv @@
// ----------------------------------------------------------------------------
// sps_checker
// Port-level checks of the cipher core, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sps_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input sps_pkg::out_item_t out_data
);

  // clearing pass follows reset
  `SPS_ASSERT_NEXT_NR(a_clear_after_rst, rst, in_stall, "not stalled after reset")
  // one request at a time
  `SPS_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accepted twice")
  `SPS_ASSERT(a_rekey_zero, out_valid && out_data.status == sps_pkg::ST_REKEYED, out_data.cipher_byte == 8'd0, "rekey result not zero")
  `SPS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

endmodule

bind sapphire_stream_cipher_core sps_checker u_sps_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
